FILE: rtl/hacp_pkg.sv
// Types, character codes and helpers shared by the hex command parser.
package hacp_pkg;

    // Parser phase
    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_SPA  = 4'd1,
        PH_HEXA = 4'd2,
        PH_SPB  = 4'd3,
        PH_HEXB = 4'd4,
        PH_EOL  = 4'd5
    } t_phase;

    // Command letter as held
    typedef enum logic [2:0] {
        LT_RI  = 3'd0,
        LT_RX  = 3'd1,
        LT_IN  = 3'd2,
        LT_OUT = 3'd3,
        LT_W   = 3'd4,
        LT_C   = 3'd5
    } t_letter;

    // Operation kind of a result word
    typedef enum logic [2:0] {
        OP_IRD  = 3'd0,
        OP_XRD  = 3'd1,
        OP_PRD  = 3'd2,
        OP_PWR  = 3'd3,
        OP_XWR  = 3'd4,
        OP_CALL = 3'd5,
        OP_EOL  = 3'd6
    } t_op;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_UC_R  = 8'h52;
    localparam logic [7:0] CH_UC_W  = 8'h57;
    localparam logic [7:0] CH_LC_I  = 8'h69;
    localparam logic [7:0] CH_LC_O  = 8'h6F;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;

    // Highest port number a port write may address
    localparam logic [7:0] PORT_MAX = 8'd6;

    // Result queue depth (a character can push two words)
    localparam int RES_DEPTH = 4;

    // One result word
    typedef struct packed {
        t_op         kind;
        logic [15:0] address;
        logic [15:0] amount;
        logic [7:0]  port;
        logic        last;
    } t_result;

    // Words produced by one character
    typedef struct packed {
        logic [1:0] count;
        t_result    ev0;
        t_result    ev1;
    } t_events;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_LC_A && c <= CH_LC_F) ||
               (c >= CH_UC_A && c <= CH_UC_F);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = (c <= CH_9) ? c[3:0] : 4'(c[3:0] + 4'd9);
        return v;
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic t_result mk_res(input t_op k, input logic [15:0] a,
                                       input logic [15:0] m, input logic [7:0] p);
        t_result r;
        r.kind    = k;
        r.address = a;
        r.amount  = m;
        r.port    = p;
        r.last    = 1'b0;
        return r;
    endfunction

endpackage

FILE: rtl/hacp_parser.sv
// Command line parser: phase and operand registers plus single-pass decode of one character.
module hacp_parser #(
    parameter int NUMBER_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_char,
    output hacp_pkg::t_events o_events
);
    import hacp_pkg::*;

    t_phase                 r_phase,  n_phase;
    t_letter                r_letter, n_letter;
    logic [NUMBER_BITS-1:0] r_acc,    n_acc;
    logic [15:0]            r_first,  n_first;
    logic [15:0]            r_wptr,   n_wptr;

    logic                   sp, eol, hx;
    logic [3:0]             hv;
    logic [NUMBER_BITS-1:0] acc_shift;
    logic [31:0]            acc_ext;
    logic [15:0]            acc16;
    logic                   main_v, eol_v;
    t_result                main_r;

    // Event that closes a read or port write command
    function automatic t_result fin_res(input t_letter l, input logic [15:0] f,
                                        input logic [15:0] m);
        t_result r;
        case (l)
            LT_RI:   r = mk_res(OP_IRD, {8'h00, f[7:0]}, m, 8'h00);
            LT_RX:   r = mk_res(OP_XRD, f, m, 8'h00);
            default: r = mk_res(OP_PWR, 16'h0000, {8'h00, m[7:0]}, f[7:0]);
        endcase
        return r;
    endfunction

    function automatic logic fin_ok(input t_letter l, input logic [15:0] f);
        return (l == LT_RI) || (l == LT_RX) || (l == LT_OUT && f[7:0] <= PORT_MAX);
    endfunction

    assign sp        = (i_char == CH_SPACE);
    assign eol       = is_eol(i_char);
    assign hx        = is_hex(i_char);
    assign hv        = hex_val(i_char);
    assign acc_shift = {r_acc[NUMBER_BITS-5:0], hv};
    assign acc_ext   = 32'(r_acc);
    assign acc16     = acc_ext[15:0];

    // Next state and events for one character
    always_comb begin
        n_phase  = r_phase;
        n_letter = r_letter;
        n_acc    = r_acc;
        n_first  = r_first;
        n_wptr   = r_wptr;
        main_v   = 1'b0;
        eol_v    = 1'b0;
        main_r   = mk_res(OP_EOL, 16'h0000, 16'h0000, 8'h00);
        unique case (r_phase)
            PH_IDLE: begin
                if (!(sp || eol)) begin
                    n_acc = '0;
                    unique case (i_char)
                        CH_LC_R: begin n_letter = LT_RI;  n_phase = PH_HEXA; end
                        CH_UC_R: begin n_letter = LT_RX;  n_phase = PH_HEXA; end
                        CH_UC_W: begin n_letter = LT_W;   n_phase = PH_HEXA; end
                        CH_LC_C: begin n_letter = LT_C;   n_phase = PH_HEXA; end
                        CH_LC_I: begin n_letter = LT_IN;  n_phase = PH_SPA;  end
                        CH_LC_O: begin n_letter = LT_OUT; n_phase = PH_SPA;  end
                        default: n_phase = PH_EOL;
                    endcase
                end
            end
            PH_SPA: begin
                if (sp) begin
                    n_phase = r_phase;
                end else if (eol) begin
                    eol_v   = 1'b1;
                    n_phase = PH_IDLE;
                end else if (hx) begin
                    n_acc   = NUMBER_BITS'(hv);
                    n_phase = PH_HEXA;
                end else begin
                    // no number: zero operands, command runs through
                    n_acc   = '0;
                    n_phase = PH_EOL;
                    if (r_letter == LT_IN) begin
                        main_v = 1'b1;
                        main_r = mk_res(OP_PRD, 16'h0000, 16'h0000, 8'h00);
                    end else if (r_letter == LT_OUT) begin
                        n_first = 16'h0000;
                        main_v  = 1'b1;
                        main_r  = mk_res(OP_PWR, 16'h0000, 16'h0000, 8'h00);
                    end
                end
            end
            PH_HEXA: begin
                if (hx) begin
                    n_acc = acc_shift;
                end else if (r_letter == LT_W) begin
                    n_wptr = acc16;
                    if (sp) begin
                        n_phase = PH_SPB;
                    end else if (eol) begin
                        eol_v   = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_EOL;
                    end
                end else if (r_letter == LT_RI || r_letter == LT_RX ||
                             r_letter == LT_OUT) begin
                    n_first = acc16;
                    if (sp) begin
                        n_phase = PH_SPB;
                    end else if (eol) begin
                        eol_v   = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        // junk right after the first number: second one is zero
                        n_acc   = '0;
                        main_v  = fin_ok(r_letter, acc16);
                        main_r  = fin_res(r_letter, acc16, 16'h0000);
                        n_phase = PH_EOL;
                    end
                end else begin
                    if (r_letter == LT_C) begin
                        main_v = 1'b1;
                        main_r = mk_res(OP_CALL, acc16, 16'h0000, 8'h00);
                    end else if (r_letter == LT_IN) begin
                        main_v = 1'b1;
                        main_r = mk_res(OP_PRD, 16'h0000, 16'h0000, acc16[7:0]);
                    end
                    eol_v   = eol;
                    n_phase = eol ? PH_IDLE : PH_EOL;
                end
            end
            PH_SPB: begin
                if (sp) begin
                    n_phase = r_phase;
                end else if (eol) begin
                    eol_v   = 1'b1;
                    n_phase = PH_IDLE;
                end else if (hx) begin
                    n_acc   = NUMBER_BITS'(hv);
                    n_phase = PH_HEXB;
                end else if (r_letter == LT_W) begin
                    // bad write value ends the line
                    n_phase = PH_EOL;
                end else begin
                    n_acc   = '0;
                    main_v  = fin_ok(r_letter, r_first);
                    main_r  = fin_res(r_letter, r_first, 16'h0000);
                    n_phase = PH_EOL;
                end
            end
            PH_HEXB: begin
                if (hx) begin
                    n_acc = acc_shift;
                end else if (r_letter == LT_W) begin
                    main_v = 1'b1;
                    main_r = mk_res(OP_XWR, r_wptr, {8'h00, acc16[7:0]}, 8'h00);
                    n_wptr = 16'(r_wptr + 16'd1);
                    if (sp) begin
                        n_phase = PH_SPB;
                    end else if (eol) begin
                        eol_v   = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_EOL;
                    end
                end else begin
                    main_v  = fin_ok(r_letter, r_first);
                    main_r  = fin_res(r_letter, r_first, acc16);
                    eol_v   = eol;
                    n_phase = eol ? PH_IDLE : PH_EOL;
                end
            end
            default: begin
                // discarding the rest of the line
                eol_v   = eol;
                n_phase = eol ? PH_IDLE : PH_EOL;
            end
        endcase
    end

    // Pack the event pair; with two words the line end is in the later slot
    always_comb begin
        o_events.count = 2'(main_v) + 2'(eol_v);
        o_events.ev0   = main_v ? main_r : mk_res(OP_EOL, 16'h0000, 16'h0000, 8'h00);
        o_events.ev1   = mk_res(OP_EOL, 16'h0000, 16'h0000, 8'h00);
        o_events.ev0.last = !(main_v && eol_v);
        o_events.ev1.last = 1'b1;
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_letter <= LT_RI;
            r_acc    <= '0;
            r_first  <= 16'h0000;
            r_wptr   <= 16'h0000;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_letter <= n_letter;
            r_acc    <= n_acc;
            r_first  <= n_first;
            r_wptr   <= n_wptr;
        end
    end

endmodule

FILE: rtl/hacp_res_queue.sv
// Small result queue: takes up to two words a cycle, hands out one while the reader is ready.
module hacp_res_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hacp_pkg::t_events i_events,
    input  logic              i_pop_ready,
    output logic              o_valid,
    output hacp_pkg::t_result o_head,
    output logic [$clog2(hacp_pkg::RES_DEPTH):0] o_level
);
    import hacp_pkg::*;

    localparam int PW = $clog2(RES_DEPTH);

    t_result        r_mem [RES_DEPTH];
    logic [PW-1:0]  r_wr,    n_wr;
    logic [PW-1:0]  r_rd,    n_rd;
    logic [PW:0]    r_level, n_level;
    logic [1:0]     push_cnt;
    logic           pop;
    logic [PW-1:0]  wr_next;

    assign push_cnt = i_push ? i_events.count : 2'd0;
    assign pop      = (r_level != '0) && i_pop_ready;
    assign wr_next  = PW'(r_wr + 1'b1);
    assign o_valid  = (r_level != '0);
    assign o_head   = r_mem[r_rd];
    assign o_level  = r_level;

    // Pointer and fill level update
    always_comb begin
        n_wr    = PW'(r_wr + PW'(push_cnt));
        n_rd    = pop ? PW'(r_rd + 1'b1) : r_rd;
        n_level = (PW+1)'(r_level + (PW+1)'(push_cnt) - (PW+1)'(pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_events.ev0;
        end
        if (push_cnt == 2'd2) begin
            r_mem[wr_next] <= i_events.ev1;
        end
    end

endmodule

FILE: rtl/ascii_hex_command_parser.sv
// Top level of the ASCII hex command line parser.
//
//  channel  | dir | word                     | handshake
//  s_axis   | in  | received character       | i_s_axis_tvalid / o_s_axis_tready
//  m_axis   | out | operation event, tlast   | o_m_axis_tvalid / i_m_axis_tready
//
// One character is decoded per cycle; its events land in a four-word queue
// that drives the output, so the first event can leave the cycle after accept.
// A character takes input only while at least two queue slots are free; a
// character giving two words (event then line end) sends them out one after the other.
// Reset (synchronous, active low) returns to skipping leading blanks and empties the queue.
// Output stalls back up through the queue to o_s_axis_tready.
module ascii_hex_command_parser #(
    parameter int NUMBER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_char
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [2:0] op_kind, [18:3] address,
                                          // [34:19] amount, [42:35] port_number
    output logic        o_m_axis_tlast
);
    import hacp_pkg::*;

    localparam int LW = $clog2(RES_DEPTH) + 1;

    logic        s_fire;
    t_events     events;
    t_result     head;
    logic [LW-1:0] level;

    assign o_s_axis_tready = (level <= LW'(RES_DEPTH - 2));
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    // Character decode
    hacp_parser #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s_fire),
        .i_char   (i_s_axis_tdata),
        .o_events (events)
    );

    // Result buffering
    hacp_res_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s_fire),
        .i_events    (events),
        .i_pop_ready (i_m_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .o_head      (head),
        .o_level     (level)
    );

    assign o_m_axis_tdata = {5'b00000, head.port, head.amount, head.address, head.kind};
    assign o_m_axis_tlast = head.last;

    // Queue never overfills
    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= LW'(RES_DEPTH))
        else $error("result queue overfilled");

    // A pair of words always ends in a line end
    a_pair_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && events.count == 2'd2) |-> (events.ev1.kind == OP_EOL && !events.ev0.last))
        else $error("second word of a pair is not a line end");

    // A character that is taken never yields more than two words
    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && events.count != 2'd0) |-> (events.count <= 2'd2))
        else $error("more than two words from one character");

endmodule
